FILE: src/plpg_pkg.sv
// ----------------------------------------------------------------------------
// plpg_pkg
// Shared types and constants for the projected line point generator.
// ----------------------------------------------------------------------------
package plpg_pkg;

  localparam int STEPS_DEF   = 40;
  localparam int STEPS_MAX_W = 6;
  localparam int COORD_W     = 16;
  localparam int PIX_W       = 9;
  localparam int FRAC_W      = 12;
  localparam int ONE_Q12     = 4096;
  localparam int CULL_Q12    = 12288;
  localparam int NUM_SH      = 14;
  localparam int QUO_W       = 18;
  localparam int DEN_W       = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam int AXES = 3;
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t             x;
    coord_t             y;
    logic [DEN_W-1:0]   den;
    logic               behind;
    logic               last;
  } point_t;

endpackage

FILE: src/plpg_front.sv
// ----------------------------------------------------------------------------
// plpg_front
// Takes segments, works out the per-step increment and remainder per axis,
// and walks the STEPS+1 interpolated points into the queue, one per cycle unless it is full.
// ----------------------------------------------------------------------------
module plpg_front #(
  parameter int STEPS = plpg_pkg::STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  plpg_pkg::coord_t start_x,
  input  plpg_pkg::coord_t start_y,
  input  plpg_pkg::coord_t start_z,
  input  plpg_pkg::coord_t end_x,
  input  plpg_pkg::coord_t end_y,
  input  plpg_pkg::coord_t end_z,
  output logic             push,
  output plpg_pkg::point_t push_data,
  input  logic             full
);
  import plpg_pkg::*;

  localparam int IDX_W  = $clog2(STEPS + 1);
  localparam int RS_W   = IDX_W + 1;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SUM_W  = COORD_W + 2;
  localparam int RCP_SH = COORD_W + STEPS_MAX_W;
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PROD_W = COORD_W + RCP_W;
  localparam longint RCP = ((longint'(1) << RCP_SH) + STEPS - 1) / STEPS;

  coord_t                    in_s    [AXES];
  coord_t                    in_e    [AXES];
  logic signed [DIFF_W-1:0]  in_diff [AXES];
  logic [COORD_W-1:0]        in_abs  [AXES];
  logic                      in_neg  [AXES];

  logic                      s1_valid;
  coord_t                    s1_s    [AXES];
  logic [COORD_W-1:0]        s1_dabs [AXES];
  logic                      s1_dneg [AXES];
  logic [PROD_W-1:0]         s1_prod [AXES];

  logic                      s2_valid;
  coord_t                    s2_s    [AXES];
  logic [COORD_W-1:0]        s2_qm   [AXES];
  logic [COORD_W-1:0]        s2_dabs [AXES];
  logic                      s2_dneg [AXES];
  logic [COORD_W-1:0]        ld_qs   [AXES];
  logic [COORD_W-1:0]        ld_rm16 [AXES];
  logic [IDX_W-1:0]          ld_rm   [AXES];
  logic signed [DIFF_W-1:0]  ld_dq   [AXES];
  logic [IDX_W-1:0]          ld_dr   [AXES];

  logic                      gen_active;
  logic [IDX_W-1:0]          gen_idx;
  coord_t                    gen_p   [AXES];
  logic [IDX_W-1:0]          gen_r   [AXES];
  logic signed [DIFF_W-1:0]  gen_dq  [AXES];
  logic [IDX_W-1:0]          gen_dr  [AXES];
  logic [RS_W-1:0]           gen_rsum[AXES];
  logic                      gen_cy  [AXES];
  logic [SUM_W-1:0]          gen_sum [AXES];
  logic [IDX_W-1:0]          gen_r_next [AXES];

  logic accept, s2_take, load, gen_last, gen_done;

  assign in_s[AX_X] = start_x;
  assign in_s[AX_Y] = start_y;
  assign in_s[AX_Z] = start_z;
  assign in_e[AX_X] = end_x;
  assign in_e[AX_Y] = end_y;
  assign in_e[AX_Z] = end_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      in_diff[a] = DIFF_W'(in_e[a]) - DIFF_W'(in_s[a]);
      in_neg[a]  = in_diff[a][DIFF_W-1];
      in_abs[a]  = in_neg[a] ? COORD_W'(-in_diff[a]) : COORD_W'(in_diff[a]);
      s1_prod[a] = PROD_W'(s1_dabs[a]) * PROD_W'(RCP);
      // floor division of the difference by STEPS
      ld_qs[a]   = s2_qm[a] * COORD_W'(STEPS);
      ld_rm16[a] = s2_dabs[a] - ld_qs[a];
      ld_rm[a]   = ld_rm16[a][IDX_W-1:0];
      if (!s2_dneg[a]) begin
        ld_dq[a] = {1'b0, s2_qm[a]};
        ld_dr[a] = ld_rm[a];
      end else if (ld_rm[a] == '0) begin
        ld_dq[a] = -$signed({1'b0, s2_qm[a]});
        ld_dr[a] = '0;
      end else begin
        ld_dq[a] = ~$signed({1'b0, s2_qm[a]});
        ld_dr[a] = IDX_W'(STEPS) - ld_rm[a];
      end
      gen_rsum[a]   = RS_W'(gen_r[a]) + RS_W'(gen_dr[a]);
      gen_cy[a]     = gen_rsum[a] >= RS_W'(STEPS);
      gen_r_next[a] = gen_cy[a] ? IDX_W'(gen_rsum[a] - RS_W'(STEPS)) : IDX_W'(gen_rsum[a]);
      gen_sum[a]    = SUM_W'(gen_p[a]) + SUM_W'(gen_dq[a]) + SUM_W'(gen_cy[a]);
    end
  end

  assign gen_last = (gen_idx == IDX_W'(STEPS));
  assign push     = gen_active && !full;
  assign gen_done = push && gen_last;
  assign load     = s2_valid && (!gen_active || gen_done);
  assign s2_take  = s1_valid && (!s2_valid || load);
  assign busy     = s1_valid && !s2_take;
  assign accept   = start && !busy;

  always_comb begin
    push_data.x      = gen_p[AX_X];
    push_data.y      = gen_p[AX_Y];
    push_data.behind = gen_p[AX_Z][COORD_W-1];
    push_data.den    = push_data.behind ? DEN_W'(ONE_Q12)
                                        : DEN_W'(gen_p[AX_Z]) + DEN_W'(ONE_Q12);
    push_data.last   = gen_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      gen_active <= 1'b0;
    end else begin
      s1_valid   <= accept || (s1_valid && !s2_take);
      s2_valid   <= s2_take || (s2_valid && !load);
      gen_active <= load || (gen_active && !gen_done);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (accept) begin
        s1_s[a]    <= in_s[a];
        s1_dabs[a] <= in_abs[a];
        s1_dneg[a] <= in_neg[a];
      end
      if (s2_take) begin
        s2_s[a]    <= s1_s[a];
        s2_qm[a]   <= s1_prod[a][RCP_SH +: COORD_W];
        s2_dabs[a] <= s1_dabs[a];
        s2_dneg[a] <= s1_dneg[a];
      end
      if (load) begin
        gen_p[a]  <= s2_s[a];
        gen_r[a]  <= '0;
        gen_dq[a] <= ld_dq[a];
        gen_dr[a] <= ld_dr[a];
      end else if (push) begin
        gen_p[a] <= COORD_W'(gen_sum[a]);
        gen_r[a] <= gen_r_next[a];
      end
    end
    if (load) begin
      gen_idx <= '0;
    end else if (push) begin
      gen_idx <= gen_idx + IDX_W'(1);
    end
  end

endmodule

FILE: src/plpg_queue.sv
// ----------------------------------------------------------------------------
// plpg_queue
// Short first-word-fall-through queue of points between front and back.
// ----------------------------------------------------------------------------
module plpg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  plpg_pkg::point_t wr_data,
  output logic             full,
  input  logic             pop,
  output plpg_pkg::point_t rd_data,
  output logic             empty
);
  import plpg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  point_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: src/plpg_back.sv
// ----------------------------------------------------------------------------
// plpg_back
// Projects each point: pipelined radix-2 divide of 4x and 4y by z+1, cull,
// then scale and offset to screen column and row.
// ----------------------------------------------------------------------------
module plpg_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               empty,
  input  plpg_pkg::point_t                   rd_data,
  output logic                               pop,
  output logic                               strobe,
  output logic signed [plpg_pkg::PIX_W-1:0]  pixel_col,
  output logic signed [plpg_pkg::PIX_W-1:0]  pixel_row,
  output logic                               visible,
  output logic                               last_point
);
  import plpg_pkg::*;

  localparam int NX_W    = 15;
  localparam int MAP_W   = 21;
  localparam int SCALE   = 30;
  localparam int HALF    = ONE_Q12 / 2;
  localparam int ROW_OFS = 20 * ONE_Q12;
  localparam int HI_SH   = QUO_W - NUM_SH;

  typedef struct packed {
    logic               v;
    logic               behind;
    logic               last;
    logic [DEN_W-1:0]   den;
    logic               xneg;
    logic               yneg;
    logic [QUO_W-1:0]   numx;
    logic [QUO_W-1:0]   numy;
    logic [DEN_W-1:0]   rx;
    logic [DEN_W-1:0]   ry;
    logic [QUO_W-1:0]   qx;
    logic [QUO_W-1:0]   qy;
  } div_t;

  function automatic div_t div_step(div_t a);
    div_t           b;
    logic [DEN_W:0] tx;
    logic [DEN_W:0] ty;
    b  = a;
    tx = {a.rx, a.numx[QUO_W-1]};
    ty = {a.ry, a.numy[QUO_W-1]};
    if (tx >= {1'b0, a.den}) begin
      b.rx = DEN_W'(tx - {1'b0, a.den});
      b.qx = {a.qx[QUO_W-2:0], 1'b1};
    end else begin
      b.rx = DEN_W'(tx);
      b.qx = {a.qx[QUO_W-2:0], 1'b0};
    end
    if (ty >= {1'b0, a.den}) begin
      b.ry = DEN_W'(ty - {1'b0, a.den});
      b.qy = {a.qy[QUO_W-2:0], 1'b1};
    end else begin
      b.ry = DEN_W'(ty);
      b.qy = {a.qy[QUO_W-2:0], 1'b0};
    end
    b.numx = a.numx << 1;
    b.numy = a.numy << 1;
    return b;
  endfunction

  function automatic logic signed [PIX_W-1:0] to_pix(logic signed [MAP_W-1:0] v);
    logic [MAP_W-1:0] m;
    logic [PIX_W-1:0] c;
    m = v[MAP_W-1] ? MAP_W'(-v) : MAP_W'(v);
    c = PIX_W'(m >> FRAC_W);
    return v[MAP_W-1] ? -c : c;
  endfunction

  div_t                     st      [QUO_W+1];
  div_t                     st_next [QUO_W+1];
  div_t                     st_in;
  logic [COORD_W-1:0]       xabs, yabs;
  logic                     fin_vis;
  logic signed [NX_W-1:0]   fin_nx, fin_ny;

  logic                     p1_valid, p1_vis, p1_last;
  logic signed [NX_W-1:0]   p1_nx, p1_ny;
  logic                     p2_valid, p2_vis, p2_last;
  logic signed [MAP_W-1:0]  p2_fc, p2_fr;

  assign pop = !empty;

  always_comb begin
    xabs         = rd_data.x[COORD_W-1] ? COORD_W'(-rd_data.x) : COORD_W'(rd_data.x);
    yabs         = rd_data.y[COORD_W-1] ? COORD_W'(-rd_data.y) : COORD_W'(rd_data.y);
    st_in.v      = pop;
    st_in.behind = rd_data.behind;
    st_in.last   = rd_data.last;
    st_in.den    = rd_data.den;
    st_in.xneg   = rd_data.x[COORD_W-1];
    st_in.yneg   = rd_data.y[COORD_W-1];
    st_in.numx   = QUO_W'({xabs, {NUM_SH{1'b0}}});
    st_in.numy   = QUO_W'({yabs, {NUM_SH{1'b0}}});
    st_in.rx     = DEN_W'(xabs >> HI_SH);
    st_in.ry     = DEN_W'(yabs >> HI_SH);
    st_in.qx     = '0;
    st_in.qy     = '0;
  end

  // divider stages; reset clears every stage's valid bit
  always_comb begin
    st_next[0]   = st_in;
    st_next[0].v = st_in.v && !rst;
    for (int k = 1; k <= QUO_W; k++) begin
      st_next[k]   = div_step(st[k-1]);
      st_next[k].v = st[k-1].v && !rst;
    end
  end

  always_comb begin
    fin_vis = !st[QUO_W].behind
              && (st[QUO_W].qx <= QUO_W'(CULL_Q12))
              && (st[QUO_W].qy <= QUO_W'(CULL_Q12));
    fin_nx  = $signed({1'b0, st[QUO_W].qx[NX_W-2:0]});
    fin_ny  = $signed({1'b0, st[QUO_W].qy[NX_W-2:0]});
    if (st[QUO_W].xneg) begin
      fin_nx = -fin_nx;
    end
    if (st[QUO_W].yneg) begin
      fin_ny = -fin_ny;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QUO_W; k++) begin
      st[k] <= st_next[k];
    end
    p1_vis  <= fin_vis;
    p1_last <= st[QUO_W].last;
    p1_nx   <= fin_nx;
    p1_ny   <= fin_ny;
    p2_vis  <= p1_vis;
    p2_last <= p1_last;
    p2_fc   <= (MAP_W'(p1_nx) + MAP_W'(2 * ONE_Q12)) * MAP_W'(SCALE) + MAP_W'(HALF);
    p2_fr   <= (MAP_W'(2 * ONE_Q12) - MAP_W'(p1_ny)) * MAP_W'(SCALE)
               + MAP_W'(ROW_OFS + HALF);
    pixel_col <= (p2_valid && p2_vis) ? to_pix(p2_fc) : '0;
    pixel_row <= (p2_valid && p2_vis) ? to_pix(p2_fr) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      strobe     <= 1'b0;
      visible    <= 1'b0;
      last_point <= 1'b0;
    end else begin
      p1_valid   <= st[QUO_W].v;
      p2_valid   <= p1_valid;
      strobe     <= p2_valid;
      visible    <= p2_valid && p2_vis;
      last_point <= p2_valid && p2_last;
    end
  end

endmodule

FILE: src/projected_line_point_generator_core.sv
// A segment passes the front's s1 and s2 registers, the point walker, the queue, the
// divider stages, p1, p2 and the output registers; its points then come out one point
// per cycle, STEPS+1 points per segment. The front sets up the next segment while the
// point walker runs the current one.
// Reset (rst, synchronous): clears all valid and control state; work in flight is
// dropped. Results cannot be stalled.
// ----------------------------------------------------------------------------
// projected_line_point_generator_core
// Segment in, projected screen points out: front walks the points, a short
// queue decouples it from the divider and mapping pipeline in the back.
// ----------------------------------------------------------------------------
module projected_line_point_generator_core #(
  parameter int STEPS = plpg_pkg::STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  plpg_pkg::coord_t                   start_x,
  input  plpg_pkg::coord_t                   start_y,
  input  plpg_pkg::coord_t                   start_z,
  input  plpg_pkg::coord_t                   end_x,
  input  plpg_pkg::coord_t                   end_y,
  input  plpg_pkg::coord_t                   end_z,
  output logic                               strobe,
  output logic signed [plpg_pkg::PIX_W-1:0]  pixel_col,
  output logic signed [plpg_pkg::PIX_W-1:0]  pixel_row,
  output logic                               visible,
  output logic                               last_point
);
  import plpg_pkg::*;

  point_t q_wr_data;
  point_t q_rd_data;
  logic   q_push, q_full, q_pop, q_empty;

  plpg_front #(
    .STEPS (STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .start_x   (start_x),
    .start_y   (start_y),
    .start_z   (start_z),
    .end_x     (end_x),
    .end_y     (end_y),
    .end_z     (end_z),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full)
  );

  plpg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  plpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .rd_data    (q_rd_data),
    .pop        (q_pop),
    .strobe     (strobe),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .visible    (visible),
    .last_point (last_point)
  );

endmodule

FILE: src/plpg_checker.sv
// ----------------------------------------------------------------------------
// plpg_checker
// Port-level checks on the result side of the core, bound to the top level.
// ----------------------------------------------------------------------------
module plpg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               strobe,
  input logic signed [plpg_pkg::PIX_W-1:0]  pixel_col,
  input logic signed [plpg_pkg::PIX_W-1:0]  pixel_row,
  input logic                               visible,
  input logic                               last_point
);

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !visible |-> pixel_col == 0 && pixel_row == 0)
    else $error("hidden point with nonzero coordinates");

  a_flags_need_strobe: assert property (@(posedge clk) disable iff (rst)
    !strobe |-> !visible && !last_point)
    else $error("flag raised without strobe");

  a_visible_range: assert property (@(posedge clk) disable iff (rst)
    strobe && visible |-> pixel_col >= -30 && pixel_col <= 150
                          && pixel_row >= -10 && pixel_row <= 170)
    else $error("visible point outside mapped range");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    last_point |=> !last_point)
    else $error("back-to-back last points");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !visible && !last_point)
    else $error("output active after reset");

endmodule

bind projected_line_point_generator_core plpg_checker u_plpg_checker (.*);
